@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the fan level controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, disabled while in reset
`define FLHC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("flhc assertion failed");

// overlapping implication, disabled while in reset
`define FLHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("flhc implication failed");

// next-cycle implication, disabled while in reset
`define FLHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("flhc next-cycle implication failed");

`endif

@@ rtl/core/flhc_pkg.sv @@
// Types and constants for the fan level hysteresis controller
package flhc_pkg;

	localparam int TEMP_BITS = 8;
	localparam int LEVEL_W   = 3;
	localparam int DW        = 22;   // shared unit datapath width

	localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd0;
	localparam logic [2:0] CFG_BIAS_GAIN     = 3'd1;
	localparam logic [2:0] CFG_BIAS_DECAY    = 3'd2;
	localparam logic [2:0] CFG_NUM_LEVELS    = 3'd3;
	localparam logic [2:0] CFG_LOW_LIMITS    = 3'd4;
	localparam logic [2:0] CFG_HIGH_LIMITS   = 3'd5;
	localparam logic [2:0] CFG_LEVEL_VALUES  = 3'd6;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2
	} alu_op_t;

	typedef struct packed {
		alu_op_t              op;
		logic signed [DW-1:0] a;
		logic signed [DW-1:0] b;
	} alu_req_t;

	function automatic logic signed [DW-1:0] sext_temp(input logic [TEMP_BITS-1:0] v);
		return {{(DW-TEMP_BITS){v[TEMP_BITS-1]}}, v};
	endfunction

endpackage

@@ rtl/core/flhc_alu.sv @@
// Shared add / subtract / multiply unit of the fan level controller
module flhc_alu import flhc_pkg::*; (
	input  alu_req_t             req,
	output logic signed [DW-1:0] res
);

	logic signed [2*DW-1:0] prod;

	assign prod = req.a * req.b;

	always_comb begin
		case (req.op)
			ALU_ADD: res = req.a + req.b;
			ALU_SUB: res = req.a - req.b;
			ALU_MUL: res = prod[DW-1:0];
			default: res = '0;
		endcase
	end

endmodule

@@ rtl/core/fan_level_hysteresis_controller_unit.sv @@
// Top level of the fan level hysteresis controller
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  in       | in_valid / in_stall | temp_sample
//  out      | out_valid/out_stall | fan_value, level_index, fan_write, next_interval
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A later sample runs the watchdog and difference steps, the two multiply steps after a rise
// of two degrees or more, then the bias add, up walk, down walk and decay steps; the first
// sample starts at the down walk. One shared add/subtract/multiply unit is used by every
// step and the level walks test one limit per cycle.
// in_stall is high from acceptance until the result enters the output register.
// A stalled result holds the sequencer in its last step. Reset is asynchronous.
`include "assert_macros.svh"

module fan_level_hysteresis_controller_unit import flhc_pkg::*; #(
	parameter int MAX_LEVELS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [TEMP_BITS-1:0] temp_sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           fan_value,
	output logic [LEVEL_W-1:0]   level_index,
	output logic                 fan_write,
	output logic [3:0]           next_interval,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_WDOG  = 10'b0000000010,
		S_DIFF  = 10'b0000000100,
		S_MUL1  = 10'b0000001000,
		S_MUL2  = 10'b0000010000,
		S_BADD  = 10'b0000100000,
		S_UP    = 10'b0001000000,
		S_DOWN  = 10'b0010000000,
		S_DECAY = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [3:0]  sample_period_q;
	logic [7:0]  bias_gain_q;
	logic [9:0]  bias_decay_q;
	logic [3:0]  num_levels_q;
	logic [63:0] low_limits_q;
	logic [63:0] high_limits_q;
	logic [63:0] level_values_q;

	// controller state
	logic                 started_q;
	logic [TEMP_BITS-1:0] prev_temp_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [3:0]           interval_q;
	logic [7:0]           wdog_q;
	logic [15:0]          bias_q;

	// per-request working registers
	logic [TEMP_BITS-1:0] temp_q;
	logic [7:0]           diffm1_q;
	logic [19:0]          prod_q;
	logic signed [17:0]   biased_q;
	logic                 write_q;

	logic [3:0]           sp_eff;
	logic [7:0]           six_sp;
	logic [3:0]           n_eff;
	logic [LEVEL_W-1:0]   n_top;
	logic [LEVEL_W-1:0]   lvl_clamped;
	logic [7:0]           low_sel;
	logic [7:0]           high_sel;
	logic                 in_acc;
	logic                 out_free;
	alu_req_t             alu_req;
	logic signed [DW-1:0] alu_res;
	logic                 res_neg;
	logic                 res_zero;

	assign sp_eff   = (sample_period_q == 4'd0) ? 4'd1 : sample_period_q;
	assign six_sp   = ({4'd0, sp_eff} << 2) + ({4'd0, sp_eff} << 1);
	always_comb begin
		if (num_levels_q == 4'd0)
			n_eff = 4'd1;
		else if (num_levels_q > 4'(MAX_LEVELS))
			n_eff = 4'(MAX_LEVELS);
		else
			n_eff = num_levels_q;
	end
	assign n_top       = LEVEL_W'(n_eff - 4'd1);
	assign lvl_clamped = (level_q > n_top) ? n_top : level_q;
	assign low_sel     = low_limits_q[{level_q, 3'b000} +: 8];
	assign high_sel    = high_limits_q[{level_q, 3'b000} +: 8];

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;

	// operand selection for the shared unit
	always_comb begin
		alu_req.op = ALU_SUB;
		alu_req.a  = '0;
		alu_req.b  = '0;
		case (state_q)
			S_WDOG: begin
				alu_req.a = DW'(wdog_q);
				alu_req.b = DW'(interval_q);
			end
			S_DIFF: begin
				alu_req.a = sext_temp(temp_q);
				alu_req.b = sext_temp(prev_temp_q);
			end
			S_MUL1: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = DW'(interval_q);
				alu_req.b  = DW'(diffm1_q);
			end
			S_MUL2: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = DW'(prod_q);
				alu_req.b  = DW'(bias_gain_q);
			end
			S_BADD: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = sext_temp(temp_q);
				alu_req.b  = DW'(bias_q);
			end
			S_UP: begin
				alu_req.a = DW'(biased_q);
				alu_req.b = sext_temp(high_sel);
			end
			S_DOWN: begin
				alu_req.a = DW'(biased_q);
				alu_req.b = sext_temp(low_sel);
			end
			S_DECAY: begin
				alu_req.a = DW'({bias_q, 4'b0000});
				alu_req.b = DW'(bias_decay_q);
			end
			default: ;
		endcase
	end

	flhc_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	assign res_neg  = alu_res[DW-1];
	assign res_zero = (alu_res == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= 4'd5;
			bias_gain_q     <= 8'd8;
			bias_decay_q    <= 10'd38;
			num_levels_q    <= 4'd8;
			low_limits_q    <= '0;
			high_limits_q   <= '0;
			level_values_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLE_PERIOD: sample_period_q <= cfg_data[3:0];
				CFG_BIAS_GAIN:     bias_gain_q     <= cfg_data[7:0];
				CFG_BIAS_DECAY:    bias_decay_q    <= cfg_data[9:0];
				CFG_NUM_LEVELS:    num_levels_q    <= cfg_data[3:0];
				CFG_LOW_LIMITS:    low_limits_q    <= cfg_data;
				CFG_HIGH_LIMITS:   high_limits_q   <= cfg_data;
				CFG_LEVEL_VALUES:  level_values_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			prev_temp_q <= '0;
			level_q     <= '0;
			interval_q  <= 4'd5;
			wdog_q      <= 8'd30;
			bias_q      <= '0;
			write_q     <= 1'b0;
			diffm1_q    <= '0;
			prod_q      <= '0;
			biased_q    <= '0;
			out_valid   <= 1'b0;
		end else begin
			// S_DONE sets out_valid itself when the output register is free
			if (out_valid && !out_stall && state_q != S_DONE)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!started_q) begin
							// first sample: walk down from the top, unbiased
							level_q    <= n_top;
							interval_q <= sp_eff;
							wdog_q     <= six_sp;
							bias_q     <= '0;
							started_q  <= 1'b1;
							write_q    <= 1'b1;
							biased_q   <= 18'(signed'(temp_sample));
							state_q    <= S_DOWN;
						end else begin
							level_q <= lvl_clamped;
							write_q <= 1'b0;
							state_q <= S_WDOG;
						end
					end
				end
				S_WDOG: begin
					if (alu_res <= signed'(DW'(sp_eff))) begin
						write_q <= 1'b1;
						wdog_q  <= six_sp;
					end else begin
						wdog_q  <= alu_res[7:0];
					end
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					// a rise of two or more degrees rebuilds the bias
					if (!res_neg && (alu_res > signed'(DW'(1)))) begin
						diffm1_q <= alu_res[7:0] - 8'd1;
						state_q  <= S_MUL1;
					end else begin
						if (interval_q < sp_eff)
							interval_q <= interval_q + 4'd1;
						state_q <= S_BADD;
					end
				end
				S_MUL1: begin
					prod_q  <= alu_res[19:0];
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (|alu_res[DW-1:20])
						bias_q <= 16'hFFFF;
					else
						bias_q <= alu_res[19:4];
					if (interval_q > 4'd2)
						interval_q <= 4'd2;
					state_q <= S_BADD;
				end
				S_BADD: begin
					biased_q <= alu_res[17:0];
					state_q  <= S_UP;
				end
				S_UP: begin
					if (!res_neg) begin
						write_q <= 1'b1;
						if (level_q < n_top)
							level_q <= level_q + 1'b1;
						else
							state_q <= S_DOWN;
					end else begin
						state_q <= S_DOWN;
					end
				end
				S_DOWN: begin
					if (res_neg || res_zero) begin
						write_q    <= 1'b1;
						interval_q <= sp_eff;
						if (level_q != '0)
							level_q <= level_q - 1'b1;
						else
							state_q <= S_DECAY;
					end else begin
						state_q <= S_DECAY;
					end
				end
				S_DECAY: begin
					if (bias_q != '0)
						bias_q <= (res_neg || res_zero) ? 16'd0 : alu_res[19:4];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						prev_temp_q <= temp_q;
						out_valid   <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			temp_q <= temp_sample;
		if (state_q == S_DONE && out_free) begin
			fan_value     <= level_values_q[{level_q, 3'b000} +: 8];
			level_index   <= level_q;
			fan_write     <= write_q;
			next_interval <= interval_q;
		end
	end

	`FLHC_ASSERT_NXT(a_accept_starts_work, clk, arst_n, in_acc, state_q != S_IDLE)
	`FLHC_ASSERT_IMP(a_level_in_range, clk, arst_n, state_q == S_DONE, level_q <= n_top)
	`FLHC_ASSERT_IMP(a_result_after_start, clk, arst_n, out_valid, started_q)
	`FLHC_ASSERT_IMP(a_interval_nonzero, clk, arst_n, state_q == S_DONE, interval_q != 4'd0)

endmodule
